/* sv/tlr_pkg.sv */
`timescale 1ns / 1ps

package tlr_pkg;

	// Width of the seconds counters and of every limit register.
	localparam int CNT_W = 7;
	// Width of the configuration register index.
	localparam int ADDR_W = 3;
	// Width of the two-digit BCD count.
	localparam int BCD_W = 8;

	typedef logic [CNT_W-1:0] cnt_t;
	typedef logic [ADDR_W-1:0] addr_t;

	// Light phases, in the encoding seen on the lamp output.
	typedef enum logic [1:0] {
		PH_RED    = 2'd0,
		PH_YELLOW = 2'd1,
		PH_GREEN  = 2'd2,
		PH_WALK   = 2'd3
	} phase_t;

	// Configuration register indexes.
	localparam addr_t REG_RED_LIMIT     = 3'd0;
	localparam addr_t REG_YELLOW_LIMIT  = 3'd1;
	localparam addr_t REG_GREEN_LIMIT   = 3'd2;
	localparam addr_t REG_REQUEST_DELAY = 3'd3;
	localparam addr_t REG_WALK_LIMIT    = 3'd4;

	// Register values after reset.
	localparam cnt_t RST_RED_LIMIT     = 7'd11;
	localparam cnt_t RST_YELLOW_LIMIT  = 7'd8;
	localparam cnt_t RST_GREEN_LIMIT   = 7'd16;
	localparam cnt_t RST_REQUEST_DELAY = 7'd5;
	localparam cnt_t RST_WALK_LIMIT    = 7'd18;

	// Tens and ones of a count below 128. The tens digit comes from a
	// multiply by 205/2048, which is exact for every value in this range;
	// the high digit may exceed nine for counts of 100 and above.
	function automatic logic [BCD_W-1:0] bcd_of(input cnt_t v);
		logic [14:0] prod;
		logic [3:0]  tens;
		logic [3:0]  ones;
		prod = 15'(v) * 15'd205;
		tens = prod[14:11];
		ones = 4'(v - 7'(tens) * 7'd10);
		return {tens, ones};
	endfunction

endpackage

/* sv/tlr_if.sv */
`timescale 1ns / 1ps

// One-second tick with the button flag.
interface tlr_in_if;
	logic valid;
	logic ready;
	logic button_seen;

	modport source (output valid, output button_seen, input ready);
	modport sink (input valid, input button_seen, output ready);
endinterface

// Phase, walk LED and BCD count after each tick.
interface tlr_out_if;
	logic                      valid;
	logic                      ready;
	logic [1:0]                lamp;
	logic                      walk_led;
	logic [tlr_pkg::BCD_W-1:0] count_bcd;

	modport source (output valid, output lamp, output walk_led, output count_bcd, input ready);
	modport sink (input valid, input lamp, input walk_led, input count_bcd, output ready);
endinterface

// Register write channel.
interface tlr_cfg_if;
	logic           valid;
	logic           ready;
	tlr_pkg::addr_t addr;
	tlr_pkg::cnt_t  data;

	modport source (output valid, output addr, output data, input ready);
	modport sink (input valid, input addr, input data, output ready);
endinterface

/* sv/traffic_light_with_request.sv */
`timescale 1ns / 1ps

// Traffic light controller with a pedestrian request button.
// The tick channel carries one beat per elapsed second, flagging whether the
// button was pressed during that second. Every tick beat yields exactly one
// beat on the result channel: the phase after the tick (red, yellow, green
// or walk), the walk LED and the seconds count as two BCD digits.
// The phase update is a single pass of logic from the state registers into
// the result register, so a result appears in the cycle after its tick is
// taken, and a tick can be taken in every cycle while the receiver does not stall.
// When the receiver stalls, the result register holds its beat and the block
// takes one more tick only if that register drains in the same cycle, so
// ticks back up without loss.
// The cfg channel writes the five limit registers and is always ready;
// writes to indexes above four are dropped. Write only while idle.
// Reset puts the light in red with both counters and the request latch
// cleared, and loads the default limits 11, 8, 16, 5 and 18 seconds.
module traffic_light_with_request (
	input  logic          clk,
	input  logic          arst_n,
	tlr_in_if.sink        tick,
	tlr_out_if.source     result,
	tlr_cfg_if.sink       cfg
);

	tlr_pkg::cnt_t   red_limit_q;
	tlr_pkg::cnt_t   yellow_limit_q;
	tlr_pkg::cnt_t   green_limit_q;
	tlr_pkg::cnt_t   request_delay_q;
	tlr_pkg::cnt_t   walk_limit_q;

	tlr_pkg::phase_t phase_q;
	tlr_pkg::cnt_t   second_count_q;
	logic            latch_q;
	tlr_pkg::cnt_t   request_count_q;

	logic                      out_valid_q;
	tlr_pkg::phase_t           out_phase_q;
	logic [tlr_pkg::BCD_W-1:0] out_bcd_q;

	tlr_pkg::phase_t phase_d;
	tlr_pkg::cnt_t   second_count_d;
	logic            latch_d;
	tlr_pkg::cnt_t   request_count_d;
	tlr_pkg::cnt_t   limit;
	tlr_pkg::phase_t successor;
	tlr_pkg::cnt_t   sc_inc;
	logic            tick_accept;

	assign tick.ready  = !out_valid_q || result.ready;
	assign tick_accept = tick.valid && tick.ready;
	assign cfg.ready   = 1'b1;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			red_limit_q     <= tlr_pkg::RST_RED_LIMIT;
			yellow_limit_q  <= tlr_pkg::RST_YELLOW_LIMIT;
			green_limit_q   <= tlr_pkg::RST_GREEN_LIMIT;
			request_delay_q <= tlr_pkg::RST_REQUEST_DELAY;
			walk_limit_q    <= tlr_pkg::RST_WALK_LIMIT;
		end else if (cfg.valid) begin
			case (cfg.addr)
				tlr_pkg::REG_RED_LIMIT:     red_limit_q     <= cfg.data;
				tlr_pkg::REG_YELLOW_LIMIT:  yellow_limit_q  <= cfg.data;
				tlr_pkg::REG_GREEN_LIMIT:   green_limit_q   <= cfg.data;
				tlr_pkg::REG_REQUEST_DELAY: request_delay_q <= cfg.data;
				tlr_pkg::REG_WALK_LIMIT:    walk_limit_q    <= cfg.data;
				default: ;
			endcase
		end
	end

	// Limit and successor of the light phase the tick starts in.
	always_comb begin
		case (phase_q)
			tlr_pkg::PH_RED: begin
				limit     = red_limit_q;
				successor = tlr_pkg::PH_YELLOW;
			end
			tlr_pkg::PH_YELLOW: begin
				limit     = yellow_limit_q;
				successor = tlr_pkg::PH_GREEN;
			end
			tlr_pkg::PH_GREEN: begin
				limit     = green_limit_q;
				successor = tlr_pkg::PH_RED;
			end
			default: begin
				limit     = walk_limit_q;
				successor = tlr_pkg::PH_GREEN;
			end
		endcase
	end

	// Next state for one tick. In a light phase the walk jump is taken first
	// and the phase limit check, on the possibly cleared count, overrides it.
	always_comb begin
		sc_inc          = second_count_q + 7'd1;
		phase_d         = phase_q;
		second_count_d  = sc_inc;
		latch_d         = latch_q;
		request_count_d = request_count_q;
		if (phase_q == tlr_pkg::PH_WALK) begin
			latch_d = 1'b0;
			if (sc_inc == limit) begin
				second_count_d = '0;
				phase_d        = successor;
			end
		end else begin
			latch_d = latch_q || tick.button_seen;
			if (latch_d) begin
				request_count_d = request_count_q + 7'd1;
			end
			if (request_count_d == request_delay_q) begin
				request_count_d = '0;
				second_count_d  = '0;
				phase_d         = tlr_pkg::PH_WALK;
			end
			if (second_count_d == limit) begin
				second_count_d = '0;
				phase_d        = successor;
			end
		end
	end

	// Controller state, advanced once per accepted tick.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q         <= tlr_pkg::PH_RED;
			second_count_q  <= '0;
			latch_q         <= 1'b0;
			request_count_q <= '0;
		end else if (tick_accept) begin
			phase_q         <= phase_d;
			second_count_q  <= second_count_d;
			latch_q         <= latch_d;
			request_count_q <= request_count_d;
		end
	end

	// Result register valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (tick.ready) begin
			out_valid_q <= tick.valid;
		end
	end

	// Result register payload.
	always_ff @(posedge clk) begin
		if (tick_accept) begin
			out_phase_q <= phase_d;
			out_bcd_q   <= tlr_pkg::bcd_of(second_count_d);
		end
	end

	assign result.valid     = out_valid_q;
	assign result.lamp      = out_phase_q;
	assign result.walk_led  = (out_phase_q == tlr_pkg::PH_WALK);
	assign result.count_bcd = out_bcd_q;

	// The walk phase is only entered with the request counter cleared, and
	// walk never counts requests.
	a_walk_rc_clear: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == tlr_pkg::PH_WALK |-> request_count_q == '0)
		else $error("request counter nonzero in walk phase");

	// A tick taken in walk leaves the request latch clear.
	a_walk_clears_latch: assert property (@(posedge clk) disable iff (!arst_n)
		tick_accept && phase_q == tlr_pkg::PH_WALK |=> !latch_q)
		else $error("request latch survived a walk tick");

	// Every accepted tick shows up as a result beat in the next cycle.
	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		tick_accept |=> result.valid)
		else $error("accepted tick produced no result");

	// The result phase matches the controller phase that the tick leads to.
	a_result_matches_state: assert property (@(posedge clk) disable iff (!arst_n)
		tick_accept |=> result.lamp == phase_q)
		else $error("result phase differs from controller phase");

endmodule

/* sim/tb_traffic_light_with_request.sv */
`timescale 1ns / 1ps

module tb_traffic_light_with_request;
	import tlr_pkg::*;

	localparam int CYCLE_LIMIT = 100000;
	localparam int REPORT_MAX  = 10;
	localparam int NUM_REGS    = 5;
	localparam int NUM_ADDRS   = 1 << ADDR_W;
	localparam int NUM_SETS    = 10;
	localparam int IDLE_PCT    = 13;

	// One result beat: lamp, walk LED and BCD seconds.
	typedef struct packed {
		phase_t           lamp;
		logic             walk_led;
		logic [BCD_W-1:0] count_bcd;
	} light_out_t;

	// One row of the opening tick table. Only rows marked typed carry a
	// hand-written expectation; the rest use the light predictor.
	typedef struct packed {
		logic       button;
		logic       typed;
		light_out_t want;
	} tick_row_t;

	// One register setting and the number of random ticks run under it.
	typedef struct packed {
		cnt_t [0:NUM_REGS-1] lim;
		int                  ticks;
		logic                rand_lims;
		logic                steady;
	} light_set_t;

	// Reset limits: a button press in red, walk after five latched seconds,
	// eighteen seconds of walk, then back to green.
	localparam tick_row_t OPENING_ROWS [25] = '{
		'{1'b0, 1'b1, '{PH_RED, 1'b0, 8'h01}},
		'{1'b1, 1'b0, '0},
		'{1'b0, 1'b0, '0},
		'{1'b0, 1'b0, '0},
		'{1'b0, 1'b0, '0},
		'{1'b0, 1'b1, '{PH_WALK, 1'b1, 8'h00}},
		'{1'b1, 1'b0, '0},
		'{1'b0, 1'b0, '0},
		'{1'b1, 1'b0, '0},
		'{1'b1, 1'b0, '0},
		'{1'b0, 1'b0, '0},
		'{1'b1, 1'b0, '0},
		'{1'b0, 1'b0, '0},
		'{1'b0, 1'b0, '0},
		'{1'b1, 1'b0, '0},
		'{1'b0, 1'b0, '0},
		'{1'b1, 1'b0, '0},
		'{1'b0, 1'b0, '0},
		'{1'b0, 1'b0, '0},
		'{1'b1, 1'b0, '0},
		'{1'b0, 1'b0, '0},
		'{1'b1, 1'b0, '0},
		'{1'b0, 1'b0, '0},
		'{1'b0, 1'b1, '{PH_GREEN, 1'b0, 8'h00}},
		'{1'b1, 1'b0, '0}
	};

	// Limits in register order: red, yellow, green, request delay, walk.
	localparam light_set_t LIGHT_SETS [NUM_SETS] = '{
		'{'{7'd1, 7'd1, 7'd1, 7'd1, 7'd1}, 40, 1'b0, 1'b0},
		'{'{7'd127, 7'd127, 7'd127, 7'd127, 7'd127}, 150, 1'b0, 1'b1},
		'{'{7'd0, 7'd0, 7'd0, 7'd0, 7'd0}, 40, 1'b0, 1'b0},
		'{'{7'd0, 7'd0, 7'd0, 7'd2, 7'd0}, 150, 1'b0, 1'b0},
		'{'{7'd3, 7'd2, 7'd4, 7'd6, 7'd2}, 40, 1'b0, 1'b0},
		'{'{7'd20, 7'd1, 7'd30, 7'd2, 7'd99}, 80, 1'b0, 1'b0},
		'{'{7'd0, 7'd0, 7'd0, 7'd0, 7'd0}, 40, 1'b1, 1'b0},
		'{'{7'd0, 7'd0, 7'd0, 7'd0, 7'd0}, 40, 1'b1, 1'b0},
		'{'{7'd0, 7'd5, 7'd5, 7'd0, 7'd3}, 40, 1'b0, 1'b0},
		'{'{7'd11, 7'd8, 7'd16, 7'd5, 7'd18}, 40, 1'b0, 1'b0}
	};

	logic clk;
	logic arst_n;

	tlr_in_if  tick_if ();
	tlr_out_if result_if ();
	tlr_cfg_if cfg_if ();

	traffic_light_with_request dut (
		.clk    (clk),
		.arst_n (arst_n),
		.tick   (tick_if),
		.result (result_if),
		.cfg    (cfg_if)
	);

	// Predicted light state and limit registers.
	cnt_t   limit_reg [NUM_REGS];
	phase_t light_phase;
	cnt_t   sec_cnt;
	cnt_t   req_cnt;
	logic   req_latched;

	light_out_t pending_lights [$];
	int         mismatch_count = 0;
	int         cycle_count = 0;
	logic       no_gaps = 1'b0;

	// Advance the predicted light by one second and return the result beat.
	function automatic light_out_t advance_light(input logic button);
		cnt_t       lim;
		phase_t     nxt;
		light_out_t r;
		int         v;
		if (light_phase == PH_WALK) begin
			req_latched = 1'b0;
			sec_cnt = sec_cnt + 1'b1;
			if (sec_cnt == limit_reg[REG_WALK_LIMIT]) begin
				sec_cnt = '0;
				light_phase = PH_GREEN;
			end
		end else begin
			case (light_phase)
				PH_RED: begin
					lim = limit_reg[REG_RED_LIMIT];
					nxt = PH_YELLOW;
				end
				PH_YELLOW: begin
					lim = limit_reg[REG_YELLOW_LIMIT];
					nxt = PH_GREEN;
				end
				default: begin
					lim = limit_reg[REG_GREEN_LIMIT];
					nxt = PH_RED;
				end
			endcase
			if (button)
				req_latched = 1'b1;
			sec_cnt = sec_cnt + 1'b1;
			if (req_latched)
				req_cnt = req_cnt + 1'b1;
			// The walk jump comes first; the end of the light phase wins over it.
			if (req_cnt == limit_reg[REG_REQUEST_DELAY]) begin
				req_cnt = '0;
				sec_cnt = '0;
				light_phase = PH_WALK;
			end
			if (sec_cnt == lim) begin
				sec_cnt = '0;
				light_phase = nxt;
			end
		end
		v = sec_cnt;
		r.lamp = light_phase;
		r.walk_led = (light_phase == PH_WALK);
		r.count_bcd = 8'(((v / 10) << 4) + (v % 10));
		return r;
	endfunction

	// Drive one tick beat after an optional gap; returns at the falling edge
	// after the beat is taken, with valid still high.
	task automatic send_tick(input logic button, input logic typed, input light_out_t want);
		light_out_t predicted;
		while (!no_gaps && $urandom_range(0, 99) < IDLE_PCT) begin
			tick_if.valid <= 1'b0;
			@(negedge clk);
		end
		tick_if.valid <= 1'b1;
		tick_if.button_seen <= button;
		@(posedge clk);
		while (!tick_if.ready)
			@(posedge clk);
		predicted = advance_light(button);
		pending_lights.push_back(typed ? want : predicted);
		@(negedge clk);
	endtask

	// Write one register; valid is left high for the caller to drop.
	task automatic write_reg(input addr_t addr, input cnt_t data);
		cfg_if.valid <= 1'b1;
		cfg_if.addr <= addr;
		cfg_if.data <= data;
		@(posedge clk);
		while (!cfg_if.ready)
			@(posedge clk);
		if (addr <= REG_WALK_LIMIT)
			limit_reg[addr] = data;
		@(negedge clk);
	endtask

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Result receiver: random stalls except during the steady stretch.
	initial begin
		result_if.ready = 1'b0;
		forever begin
			@(negedge clk);
			result_if.ready <= no_gaps || ($urandom_range(0, 99) >= IDLE_PCT);
		end
	end

	// Compare every result beat with the oldest pending expectation.
	always @(posedge clk) begin
		light_out_t want;
		if (arst_n && result_if.valid && result_if.ready) begin
			if (pending_lights.size() == 0) begin
				mismatch_count++;
				if (mismatch_count <= REPORT_MAX)
					$display("unexpected result beat: lamp %0d walk_led %0d count_bcd %h",
						result_if.lamp, result_if.walk_led, result_if.count_bcd);
			end else begin
				want = pending_lights.pop_front();
				if (result_if.lamp !== want.lamp || result_if.walk_led !== want.walk_led ||
					result_if.count_bcd !== want.count_bcd) begin
					mismatch_count++;
					if (mismatch_count <= REPORT_MAX)
						$display("result beat differs: lamp %0d/%0d walk_led %0d/%0d count_bcd %h/%h (expected/actual)",
							want.lamp, result_if.lamp, want.walk_led, result_if.walk_led,
							want.count_bcd, result_if.count_bcd);
				end
			end
		end
	end

	// Watchdog on the total run length.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("traffic_light_with_request: mismatch");
			$finish;
		end
	end

	initial begin
		int   press_pct;
		cnt_t val;
		arst_n = 1'b0;
		tick_if.valid = 1'b0;
		tick_if.button_seen = 1'b0;
		cfg_if.valid = 1'b0;
		cfg_if.addr = '0;
		cfg_if.data = '0;
		limit_reg = '{RST_RED_LIMIT, RST_YELLOW_LIMIT, RST_GREEN_LIMIT,
			RST_REQUEST_DELAY, RST_WALK_LIMIT};
		light_phase = PH_RED;
		sec_cnt = '0;
		req_cnt = '0;
		req_latched = 1'b0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Opening table under the reset limits.
		foreach (OPENING_ROWS[i])
			send_tick(OPENING_ROWS[i].button, OPENING_ROWS[i].typed, OPENING_ROWS[i].want);
		tick_if.valid <= 1'b0;

		// Each setting: drain, rewrite every index, then random ticks.
		for (int s = 0; s < NUM_SETS; s++) begin
			while (pending_lights.size() != 0)
				@(negedge clk);
			for (int a = 0; a < NUM_ADDRS; a++) begin
				if (a >= NUM_REGS)
					val = cnt_t'($urandom);
				else if (LIGHT_SETS[s].rand_lims)
					val = cnt_t'($urandom_range(1, 99));
				else
					val = LIGHT_SETS[s].lim[a];
				write_reg(addr_t'(a), val);
			end
			cfg_if.valid <= 1'b0;
			no_gaps = LIGHT_SETS[s].steady;
			// Button density per setting; none at all lets light phases wrap.
			case ($urandom_range(0, 3))
				0: press_pct = 0;
				1: press_pct = 3;
				2: press_pct = 15;
				default: press_pct = 50;
			endcase
			for (int n = 0; n < LIGHT_SETS[s].ticks; n++)
				send_tick($urandom_range(0, 99) < press_pct, 1'b0, '0);
			tick_if.valid <= 1'b0;
			no_gaps = 1'b0;
		end

		while (pending_lights.size() != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
		if (mismatch_count == 0)
			$display("traffic_light_with_request: match");
		else
			$display("traffic_light_with_request: mismatch");
		$finish;
	end

endmodule
